// ----- rtl/bir_pkg.sv -----
`timescale 1ns / 1ps
package bir_pkg;

   localparam int DefMaxSrcWidth  = 256;
   localparam int DefMaxSrcHeight = 256;
   localparam int FracBits        = 16;
   localparam int AccW            = 48;
   localparam int CfgW            = 13;

   localparam logic [1:0] CSR_SRC_W = 2'd0;
   localparam logic [1:0] CSR_SRC_H = 2'd1;
   localparam logic [1:0] CSR_DST_W = 2'd2;
   localparam logic [1:0] CSR_DST_H = 2'd3;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [7:0]  in_red;
      logic [7:0]  in_green;
      logic [7:0]  in_blue;
      logic [7:0]  in_alpha;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic       load;      // capture request
      logic       wr_pix;    // write pixel into frame
      logic       div_start; // start both axis dividers
      logic       map;       // compute integer part and fraction
      logic       rd;        // issue tap read
      logic [1:0] rd_r;
      logic [1:0] rd_c;
      logic       tap;       // read data valid for tap
      logic [1:0] tap_c;
      logic       row_fin;   // run row filter on tap line
      logic [1:0] row_idx;
      logic       col_fin;   // run column filter
      logic       fin_step;  // filter pipeline step
      logic [2:0] fin_ph;
   } bir_cmd_type;

   typedef struct packed {
      logic div_busy;
   } bir_sts_type;

   function automatic logic [7:0] sat8(input logic signed [AccW-1:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > AccW'(255 * 65536)) r = 8'd255;
      else r = v[23:16];
      return r;
   endfunction

endpackage

// ----- rtl/bir_div.sv -----
`timescale 1ns / 1ps
module bir_div
   import bir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] num,
   input  logic [12:0] den,
   output logic        busy,
   output logic [16:0] quo
);
   // restoring divider, one quotient bit a cycle
   logic [27:0] rem_ff, rem_in;
   logic [27:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [13:0] part;
   logic [13:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      part    = '0;
      diff    = '0;
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         cnt_in  = 5'd28;
         busy_in = (den != '0);
         if (den == '0) q_in = '0;
      end else if (busy_ff) begin
         part = {rem_ff[12:0], q_ff[27]};
         diff = part - {1'b0, den};
         if (part >= {1'b0, den}) begin
            rem_in = {15'd0, diff[12:0]};
            q_in   = {q_ff[26:0], 1'b1};
         end else begin
            rem_in = {14'd0, part};
            q_in   = {q_ff[26:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff[16:0];
endmodule

// ----- rtl/bir_datapath.sv -----
`timescale 1ns / 1ps
module bir_datapath
   import bir_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = DefMaxSrcWidth,
   parameter int MAX_SRC_HEIGHT = DefMaxSrcHeight
)(
   input  logic         clock,
   input  logic         reset,
   input  bir_cmd_type  cmd,
   output bir_sts_type  sts,
   input  req_word_type req_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_data,
   output rsp_word_type rsp_word
);
   localparam int XW = $clog2(MAX_SRC_WIDTH);
   localparam int YW = $clog2(MAX_SRC_HEIGHT);
   localparam int AW = XW + YW;
   localparam int DEPTH = 1 << AW;

   // configuration registers
   logic [8:0]  src_w_ff, src_h_ff;
   logic [12:0] dst_w_ff, dst_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd256;
         src_h_ff <= 9'd256;
         dst_w_ff <= 13'd256;
         dst_h_ff <= 13'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_W: src_w_ff <= csr_data[8:0];
            CSR_SRC_H: src_h_ff <= csr_data[8:0];
            CSR_DST_W: dst_w_ff <= csr_data;
            CSR_DST_H: dst_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective source size
   logic [12:0] eff_w, eff_h;
   always_comb begin
      if (src_w_ff == '0) eff_w = 13'd1;
      else if (13'(src_w_ff) > 13'(MAX_SRC_WIDTH)) eff_w = 13'(MAX_SRC_WIDTH);
      else eff_w = 13'(src_w_ff);
      if (src_h_ff == '0) eff_h = 13'd1;
      else if (13'(src_h_ff) > 13'(MAX_SRC_HEIGHT)) eff_h = 13'(MAX_SRC_HEIGHT);
      else eff_h = 13'(src_h_ff);
   end

   // request capture
   req_word_type rq_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) rq_ff <= req_word;
   end

   // destination position clipped to dst-1
   logic [12:0] dx, dy;
   logic [11:0] px, py;
   always_comb begin
      dx = (dst_w_ff == '0) ? 13'd0 : dst_w_ff - 13'd1;
      dy = (dst_h_ff == '0) ? 13'd0 : dst_h_ff - 13'd1;
      px = (13'(rq_ff.pos_x) > dx) ? 12'(dx) : rq_ff.pos_x;
      py = (13'(rq_ff.pos_y) > dy) ? 12'(dy) : rq_ff.pos_y;
   end

   logic        bx_busy, by_busy;
   logic [16:0] ux, uy;
   bir_div u_divx (.clock, .reset, .start(cmd.div_start), .num({px, 16'd0}),
                   .den(dx), .busy(bx_busy), .quo(ux));
   bir_div u_divy (.clock, .reset, .start(cmd.div_start), .num({py, 16'd0}),
                   .den(dy), .busy(by_busy), .quo(uy));
   assign sts.div_busy = bx_busy | by_busy;

   // map to source position
   logic signed [30:0] sx, sy;
   logic signed [14:0] xi_ff, yi_ff, xi_in, yi_in;
   logic [15:0] xf_ff, yf_ff;
   always_comb begin
      sx = $signed({1'b0, 30'(ux * eff_w)}) - 31'sd32768;
      sy = $signed({1'b0, 30'(uy * eff_h)}) - 31'sd32768;
      xi_in = (sx < 0) ? -15'($signed(-sx) >>> 16) : 15'(sx >>> 16);
      yi_in = (sy < 0) ? -15'($signed(-sy) >>> 16) : 15'(sy >>> 16);
   end
   always_ff @(posedge clock) begin
      if (cmd.map) begin
         xi_ff <= xi_in;
         yi_ff <= yi_in;
         xf_ff <= sx[15:0];
         yf_ff <= sy[15:0];
      end
   end

   // neighbour address with edge clamp
   logic signed [15:0] xx, yy;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   always_comb begin
      xx = 16'(xi_ff) - 16'sd1 + 16'($unsigned(cmd.rd_c));
      yy = 16'(yi_ff) - 16'sd1 + 16'($unsigned(cmd.rd_r));
      if (xx < 0) cx = '0;
      else if (xx > 16'(eff_w) - 16'sd1) cx = XW'(eff_w - 13'd1);
      else cx = XW'(xx);
      if (yy < 0) cy = '0;
      else if (yy > 16'(eff_h) - 16'sd1) cy = YW'(eff_h - 13'd1);
      else cy = YW'(yy);
   end

   // frame memory
   logic [31:0] mem [DEPTH];
   logic [31:0] rd_ff;
   logic        wr_ok;
   assign wr_ok = (13'(rq_ff.pos_x) < eff_w) && (13'(rq_ff.pos_y) < eff_h);
   always_ff @(posedge clock) begin
      if (cmd.wr_pix && wr_ok)
         mem[{rq_ff.pos_y[YW-1:0], rq_ff.pos_x[XW-1:0]}] <=
            {rq_ff.in_alpha, rq_ff.in_blue, rq_ff.in_green, rq_ff.in_red};
      if (cmd.rd) rd_ff <= mem[AW'({cy, cx})];
   end

   // tap line for one row, four channels
   logic [31:0] tapw_ff [4];
   always_ff @(posedge clock) begin
      if (cmd.tap) tapw_ff[cmd.tap_c] <= rd_ff;
   end

   // shared cubic unit: channels processed in parallel lanes
   logic signed [AccW-1:0] pa [4], pb [4], pc [4], pd [4];
   logic signed [AccW-1:0] col_ff [4][4];
   logic [15:0] tt;
   logic signed [AccW-1:0] ca_ff [4], cb_ff [4], cc_ff [4], b0_ff [4];
   logic signed [AccW-1:0] acc_ff [4];
   logic [15:0] t2_ff, t3_ff;
   logic [1:0]  dst_row_ff;
   logic        colmode_ff;

   function automatic logic signed [AccW-1:0] halve(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] r;
      r = (v < 0) ? -((-v) >>> 1) : (v >>> 1);
      return r;
   endfunction

   function automatic logic signed [AccW-1:0] mq(input logic signed [AccW-1:0] v,
                                                 input logic [15:0] t);
      logic signed [AccW+17:0] p;
      logic signed [AccW-1:0] r;
      p = 66'(v) * $signed({2'b0, t});
      r = (p < 0) ? -AccW'((-p) >>> 16) : AccW'(p >>> 16);
      return r;
   endfunction

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (cmd.col_fin) begin
            pa[k] = col_ff[k][0]; pb[k] = col_ff[k][1];
            pc[k] = col_ff[k][2]; pd[k] = col_ff[k][3];
         end else begin
            pa[k] = AccW'({tapw_ff[0][8*k +: 8], 16'd0});
            pb[k] = AccW'({tapw_ff[1][8*k +: 8], 16'd0});
            pc[k] = AccW'({tapw_ff[2][8*k +: 8], 16'd0});
            pd[k] = AccW'({tapw_ff[3][8*k +: 8], 16'd0});
         end
      end
      tt = colmode_ff ? yf_ff : xf_ff;
   end

   // phase 0 coefficients, 1 t2, 2 t3, 3 p1+a*t3, 4 +b*t2, 5 +c*t, stored to col_ff in row passes
   always_ff @(posedge clock) begin
      if (cmd.row_fin || cmd.col_fin) begin
         colmode_ff <= cmd.col_fin;
         dst_row_ff <= cmd.row_idx;
         for (int k = 0; k < 4; k++) begin
            ca_ff[k] <= halve(-pa[k] + 3 * pb[k] - 3 * pc[k] + pd[k]);
            cb_ff[k] <= halve(2 * pa[k] - 5 * pb[k] + 4 * pc[k] - pd[k]);
            cc_ff[k] <= halve(pc[k] - pa[k]);
            b0_ff[k] <= pb[k];
         end
      end else if (cmd.fin_step) begin
         case (cmd.fin_ph)
            3'd1: t2_ff <= 16'((32'(tt) * 32'(tt)) >> 16);
            3'd2: t3_ff <= 16'((32'(t2_ff) * 32'(tt)) >> 16);
            3'd3: for (int k = 0; k < 4; k++) acc_ff[k] <= b0_ff[k] + mq(ca_ff[k], t3_ff);
            3'd4: for (int k = 0; k < 4; k++) acc_ff[k] <= acc_ff[k] + mq(cb_ff[k], t2_ff);
            3'd5: begin
               for (int k = 0; k < 4; k++) begin
                  if (!colmode_ff) col_ff[k][dst_row_ff] <= acc_ff[k] + mq(cc_ff[k], tt);
                  else acc_ff[k] <= acc_ff[k] + mq(cc_ff[k], tt);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_word.out_red   = sat8(acc_ff[0]);
   assign rsp_word.out_green = sat8(acc_ff[1]);
   assign rsp_word.out_blue  = sat8(acc_ff[2]);
   assign rsp_word.out_alpha = sat8(acc_ff[3]);
endmodule

// ----- rtl/bir_ctrl.sv -----
`timescale 1ns / 1ps
module bir_ctrl
   import bir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  bir_sts_type sts,
   output bir_cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEC  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MAP  = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_FILT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [3:0] rc_ff, rc_in;    // read counter, row and column
   logic [2:0] ph_ff, ph_in;
   logic       tv_ff, tv_in;    // read data valid
   logic [1:0] tc_ff;
   logic       colp_ff, colp_in; // column pass running
   logic [1:0] fr_ff, fr_in;
   logic       type_ff;
   logic       out_v_ff, out_v_in;
   logic       acc;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || out_v_ff;
   assign rsp_valid = out_v_ff;

   always_comb begin
      st_in    = st_ff;
      rc_in    = rc_ff;
      ph_in    = ph_ff;
      tv_in    = 1'b0;
      colp_in  = colp_ff;
      fr_in    = fr_ff;
      out_v_in = out_v_ff && rsp_stall;
      cmd      = '0;
      cmd.load = acc;
      cmd.rd_r = rc_ff[3:2];
      cmd.rd_c = rc_ff[1:0];
      cmd.tap   = tv_ff;
      cmd.tap_c = tc_ff;
      cmd.row_idx = fr_ff;
      cmd.fin_ph  = ph_ff;
      unique case (st_ff)
         ST_IDLE: if (acc) st_in = ST_DEC;
         ST_DEC: begin
            if (type_ff == REQ_WRITE) begin
               cmd.wr_pix = 1'b1;
               st_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               st_in = ST_DIV;
            end
         end
         ST_DIV: if (!sts.div_busy) st_in = ST_MAP;
         ST_MAP: begin
            cmd.map = 1'b1;
            rc_in = '0;
            colp_in = 1'b0;
            st_in = ST_READ;
         end
         ST_READ: begin
            // read one row of four taps, then filter it
            cmd.rd = 1'b1;
            tv_in = 1'b1;
            rc_in = rc_ff + 4'd1;
            if (rc_ff[1:0] == 2'd3) begin
               st_in = ST_FILT;
               ph_in = 3'd0;
               fr_in = rc_ff[3:2];
            end
         end
         ST_FILT: begin
            if (ph_ff == 3'd0) begin
               if (!tv_ff) begin
                  if (colp_ff) cmd.col_fin = 1'b1;
                  else cmd.row_fin = 1'b1;
                  ph_in = 3'd1;
               end
            end else begin
               cmd.fin_step = 1'b1;
               ph_in = ph_ff + 3'd1;
               if (ph_ff == 3'd5) begin
                  if (colp_ff) begin
                     st_in = ST_DONE;
                  end else if (fr_ff == 2'd3) begin
                     colp_in = 1'b1;
                     ph_in = 3'd0;
                  end else begin
                     st_in = ST_READ;
                  end
               end
            end
         end
         ST_DONE: begin
            out_v_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         out_v_ff <= 1'b0;
         tv_ff    <= 1'b0;
         colp_ff  <= 1'b0;
         rc_ff    <= '0;
         ph_ff    <= '0;
         fr_ff    <= '0;
      end else begin
         st_ff    <= st_in;
         out_v_ff <= out_v_in;
         tv_ff    <= tv_in;
         colp_ff  <= colp_in;
         rc_ff    <= rc_in;
         ph_ff    <= ph_in;
         fr_ff    <= fr_in;
      end
      tc_ff <= rc_ff[1:0];
      if (acc) type_ff <= req_type;
   end
endmodule

// ----- rtl/bicubic_image_resampler.sv -----
// Pixel write: accepted, then written to the frame memory, no result.
// Sample: coordinate dividers, then four rows of four reads from the frame
// memory, each row followed by a filter pass, then a column pass, then rsp_valid.
// One item in flight at a time.
// Synchronous active-high reset clears control and loads the size registers
// with 256; the frame memory is undefined until written.
`timescale 1ns / 1ps
module bicubic_image_resampler
   import bir_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = DefMaxSrcWidth,
   parameter int MAX_SRC_HEIGHT = DefMaxSrcHeight
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_data
);
   bir_cmd_type cmd;
   bir_sts_type sts;

   bir_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type(req_word.req_type),
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   bir_datapath #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT))
   u_dp (
      .clock, .reset, .cmd, .sts, .req_word, .csr_write, .csr_index, .csr_data,
      .rsp_word
   );
endmodule

// ----- rtl/bir_checker.sv -----
`timescale 1ns / 1ps
module bir_checker
   import bir_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);
   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed under stall");

   // no new request while a result waits
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // result cannot follow an accept in the next cycle
   a_min_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early");
endmodule

bind bicubic_image_resampler bir_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_word
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import bir_pkg::*;

   localparam int FrameW   = 256;
   localparam int FrameH   = 256;
   localparam int OneQ     = 65536;
   localparam int HalfQ    = 32768;
   localparam int IdleMax  = 5000;
   localparam int SettleCy = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_write;
   logic [1:0]   csr_index;
   logic [12:0]  csr_data;

   bicubic_image_resampler dut (.*);

   // shadow of the frame memory and the size registers
   logic [31:0] pixel_shadow [FrameW*FrameH];
   int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

   rsp_word_type pixel_queue[$];
   int unsigned  errors;
   int unsigned  writes_sent, samples_sent, pixels_checked;
   int unsigned  quiet_cycles;
   bit           steady_mode;
   bit           hold_done;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
   } stim_row_type;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint eff_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // map one destination coordinate to source integer part and fraction
   function automatic void axis_map(input longint pos, input longint dst, input longint size,
                                    output longint ipart, output longint frac);
      longint d, u, s, fl;
      d = (dst == 0) ? 0 : dst - 1;
      u = 0;
      if (pos > d) pos = d;
      if (d != 0) u = (pos * OneQ) / d;
      s = u * size - HalfQ;
      ipart = s / OneQ;
      fl = (s >= 0) ? s / OneQ : -((-s + (OneQ - 1)) / OneQ);
      frac = s - fl * OneQ;
   endfunction

   function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
      longint ka, kb, kc, t2, t3;
      ka = (-p0 + 3 * p1 - 3 * p2 + p3) / 2;
      kb = (2 * p0 - 5 * p1 + 4 * p2 - p3) / 2;
      kc = (p2 - p0) / 2;
      t2 = (t * t) / OneQ;
      t3 = (t2 * t) / OneQ;
      return (ka * t3) / OneQ + (kb * t2) / OneQ + (kc * t) / OneQ + p1;
   endfunction

   function automatic longint clip(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // filter the 4x4 neighborhood around a destination pixel
   function automatic rsp_word_type resample_pixel(req_word_type w);
      longint sw, sh, xi, xf, yi, yf, yy, xx, v;
      longint col[4];
      longint tap[4];
      logic [7:0] chan[4];
      sw = eff_dim(src_w_reg, FrameW);
      sh = eff_dim(src_h_reg, FrameH);
      axis_map(w.pos_x, dst_w_reg, sw, xi, xf);
      axis_map(w.pos_y, dst_h_reg, sh, yi, yf);
      for (int ch = 0; ch < 4; ch++) begin
         for (int r = 0; r < 4; r++) begin
            yy = clip(yi - 1 + r, sh - 1);
            for (int c = 0; c < 4; c++) begin
               xx = clip(xi - 1 + c, sw - 1);
               tap[c] = longint'((pixel_shadow[yy*FrameW + xx] >> (8 * ch)) & 8'hFF) * OneQ;
            end
            col[r] = catmull(tap[0], tap[1], tap[2], tap[3], xf);
         end
         v = catmull(col[0], col[1], col[2], col[3], yf);
         if (v < 0) chan[ch] = 8'd0;
         else if (v > 255 * longint'(OneQ)) chan[ch] = 8'd255;
         else chan[ch] = 8'(v / OneQ);
      end
      return '{out_red: chan[0], out_green: chan[1], out_blue: chan[2], out_alpha: chan[3]};
   endfunction

   // update the shadow frame, or queue the expected pixel for a sample
   function automatic void track_word(req_word_type w, bit typed, rsp_word_type want);
      if (w.req_type == REQ_WRITE) begin
         writes_sent++;
         if (w.pos_x < eff_dim(src_w_reg, FrameW) && w.pos_y < eff_dim(src_h_reg, FrameH))
            pixel_shadow[w.pos_y*FrameW + w.pos_x] =
               {w.in_alpha, w.in_blue, w.in_green, w.in_red};
      end else begin
         samples_sent++;
         pixel_queue.push_back(typed ? want : resample_pixel(w));
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one word, hold it until taken, then idle for a random gap, which may be zero
   task automatic send_word(req_word_type w, bit typed, rsp_word_type want);
      int unsigned gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      track_word(w, typed, want);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_pixel(req_word_type w);
      send_word(w, 1'b0, '0);
   endtask

   // drain outstanding pixels, then let a trailing write settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pixel_queue.size() == 0);
      repeat (SettleCy) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SRC_W: src_w_reg = value & 13'h1FF;
         CSR_SRC_H: src_h_reg = value & 13'h1FF;
         CSR_DST_W: dst_w_reg = value;
         CSR_DST_H: dst_h_reg = value;
         default: ;
      endcase
   endtask

   task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
      wait_drained();
      write_csr(CSR_SRC_W, 13'(sw));
      write_csr(CSR_SRC_H, 13'(sh));
      write_csr(CSR_DST_W, 13'(dw));
      write_csr(CSR_DST_H, 13'(dh));
   endtask

   function automatic req_word_type rand_word(bit kind);
      req_word_type w;
      w = '{default: '0};
      w.req_type = kind;
      w.pos_x    = 12'($urandom);
      w.pos_y    = 12'($urandom);
      w.in_red   = 8'($urandom);
      w.in_green = 8'($urandom);
      w.in_blue  = 8'($urandom);
      w.in_alpha = 8'($urandom);
      return w;
   endfunction

   // cover every pixel of the active source frame so samples read defined data
   task automatic fill_frame();
      req_word_type w;
      for (int y = 0; y < eff_dim(src_h_reg, FrameH); y++)
         for (int x = 0; x < eff_dim(src_w_reg, FrameW); x++) begin
            w = rand_word(REQ_WRITE);
            w.pos_x = 12'(x);
            w.pos_y = 12'(y);
            send_pixel(w);
         end
   endtask

   // mostly samples near the destination grid, some rewrites and stray writes
   task automatic random_burst(int unsigned count);
      req_word_type w;
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            w = rand_word(REQ_SAMPLE);
            if ($urandom_range(0, 3) != 0) begin
               w.pos_x = 12'($urandom_range(0, dst_w_reg + 2));
               w.pos_y = 12'($urandom_range(0, dst_h_reg + 2));
            end
         end else if (r < 90) begin
            w = rand_word(REQ_WRITE);
            w.pos_x = 12'($urandom_range(0, eff_dim(src_w_reg, FrameW) - 1));
            w.pos_y = 12'($urandom_range(0, eff_dim(src_h_reg, FrameH) - 1));
         end else begin
            w = rand_word(REQ_WRITE);
         end
         send_pixel(w);
      end
   endtask

   // receiver stall pattern, with one long hold-off once samples are flowing
   initial begin
      int unsigned r, run;
      rsp_stall = 1'b1;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && samples_sent >= 150) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (steady_mode || r < 60) run = 1;
         else if (r < 95) run = $urandom_range(1, 4);
         else run = $urandom_range(20, 120);
         rsp_stall <= !(steady_mode || r < 60);
         repeat (run - 1) @(negedge clock);
      end
   end

   // compare each delivered pixel with the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel %h", $time, rsp_word);
            errors++;
         end else begin
            want = pixel_queue.pop_front();
            pixels_checked++;
            if (rsp_word.out_red !== want.out_red)
               $display("%0t: red exp %h got %h", $time, want.out_red, rsp_word.out_red);
            if (rsp_word.out_green !== want.out_green)
               $display("%0t: green exp %h got %h", $time, want.out_green, rsp_word.out_green);
            if (rsp_word.out_blue !== want.out_blue)
               $display("%0t: blue exp %h got %h", $time, want.out_blue, rsp_word.out_blue);
            if (rsp_word.out_alpha !== want.out_alpha)
               $display("%0t: alpha exp %h got %h", $time, want.out_alpha, rsp_word.out_alpha);
            if (rsp_word !== want) errors++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleMax) begin
         $display("%0t: no progress, %0d pixels outstanding", $time, pixel_queue.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type rows[$];
      req_word_type w;
      errors = 0;
      writes_sent = 0;
      samples_sent = 0;
      pixels_checked = 0;
      quiet_cycles = 0;
      steady_mode = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write = 1'b0;
      csr_index = CSR_SRC_W;
      csr_data = '0;
      src_w_reg = 256;
      src_h_reg = 256;
      dst_w_reg = 256;
      dst_h_reg = 256;
      foreach (pixel_shadow[i]) pixel_shadow[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-pixel frame: any position gives back the stored pixel
      set_sizes(1, 1, 1, 1);
      rows = '{
         '{'{REQ_WRITE, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{REQ_SAMPLE, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'hFFFFFFFF},
         '{'{REQ_SAMPLE, 12'hFFF, 12'hFFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'hFFFFFFFF},
         '{'{REQ_WRITE, 12'd1, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{REQ_WRITE, 12'd0, 12'hFFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{REQ_SAMPLE, 12'd7, 12'd3, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'hFFFFFFFF},
         '{'{REQ_WRITE, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{REQ_SAMPLE, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 32'h00000000},
         '{'{REQ_WRITE, 12'd0, 12'd0, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b0, '0},
         '{'{REQ_SAMPLE, 12'hFFF, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h12345678},
         '{'{REQ_WRITE, 12'hFFF, 12'hFFF, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, '0},
         '{'{REQ_SAMPLE, 12'd1, 12'hABC, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
      };
      foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].want);

      // 4x4 frame with a hard black and white checker, upscaled
      set_sizes(4, 4, 13, 7);
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 4; x++) begin
            w = '{REQ_WRITE, 12'(x), 12'(y), 8'h00, 8'h00, 8'h00, 8'h00};
            if ((x + y) % 2 == 1) w = '{REQ_WRITE, 12'(x), 12'(y), 8'hFF, 8'hFF, 8'hFF, 8'hFF};
            send_pixel(w);
         end
      for (int i = 0; i < 8; i++) begin
         w = '{REQ_SAMPLE, 12'(i), 12'(i), 8'h00, 8'h00, 8'h00, 8'h00};
         send_pixel(w);
      end

      // random phases over a range of source and destination sizes
      set_sizes(4, 4, 2, 4096);    fill_frame(); random_burst(120);
      steady_mode = 1'b1;
      set_sizes(7, 3, 0, 1);       fill_frame(); random_burst(60);
      steady_mode = 1'b0;
      set_sizes(16, 9, 37, 23);    fill_frame(); random_burst(150);
      set_sizes(300, 1, 8191, 5);  fill_frame(); random_burst(120);
      set_sizes(1, 256, 3, 4095);  fill_frame(); random_burst(120);
      set_sizes(0, 5, 1, 9);       fill_frame(); random_burst(60);
      set_sizes(12, 0, 100, 2);    fill_frame(); random_burst(60);
      set_sizes(8, 8, 4, 3);       fill_frame(); random_burst(150);

      // drain and close
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pixel_queue.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d pixel writes and %0d samples; %0d pixels compared.",
               writes_sent, samples_sent, pixels_checked);
      $display("Source sizes 1x1 to 256x1, destination sizes 0 to 8191, with stalls.");
      if (errors == 0 && pixel_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bir_pkg.sv
rtl/bir_div.sv
rtl/bir_datapath.sv
rtl/bir_ctrl.sv
rtl/bicubic_image_resampler.sv
rtl/bir_checker.sv
sim/tb.sv
